// ===== hw/rtl/hcb_pkg.sv =====
// Shared types, constants and state encoding for the Huffman code builder.
// Used by huffman_code_builder; no dependencies of its own.
package hcb_pkg;

    localparam int ALPHABET_DEF     = 256;
    localparam int MAX_CODE_LEN_DEF = 48;
    localparam int FREQ_BITS_DEF    = 24;

    localparam int CODE_W  = 48;   // code_bits field
    localparam int LEN_W   = 6;    // code_len field
    localparam int DEPTH_W = 8;    // tree depth held per node
    localparam int WT_W    = 32;   // node weight, exact sum of frequencies

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  symbol;
        logic [23:0] weight;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
        logic              has_code;
        logic              status;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_COL_RD,
        S_COL_EV,
        S_SC_RD,
        S_SC_EV,
        S_MERGE,
        S_T_ROOT,
        S_T_RD,
        S_T_W0,
        S_T_W1,
        S_L_RD,
        S_L_WR,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/huffman_code_builder.sv =====
// Huffman code builder top level: sequencer, forest scan and tree walk.
// Depends on hcb_pkg and hcb_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   per transaction: load a symbol frequency, build codes, or look up a code.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result transaction per command, in order.
// Sequencing and throughput:
//   Load and unused commands: result registered in the cycle after accept,
//   one per cycle while the receiver does not stall.
//   Lookup: registered code RAM read, then S_LOOK registers the result; the
//   next item can be taken as the result register fills, unless stalled.
//   Build: S_COL_RD and S_COL_EV per symbol collect the nonzero symbols, then
//   each of the s-1 merges runs S_SC_RD and S_SC_EV per forest slot and one
//   S_MERGE (one shared min-pair compare stepping through every forest slot,
//   one slot RAM read per slot), then S_T_RD, S_T_W0 and S_T_W1 per internal
//   node for the code walk and S_L_RD and S_L_WR per leaf for the write-back.
//   The input stalls until the build result is registered.
// Reset: clears the sequencer, the frequency valid bits (all frequencies read
//   as zero) and the code flags (every lookup misses). No clearing pass.
// Receiver stall: the result register holds; the input stalls while a held
//   result cannot be replaced.
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int ALPHABET     = ALPHABET_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int FREQ_BITS    = FREQ_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int NODES  = 2 * ALPHABET - 1;
    localparam int SLOT_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(ALPHABET + 1);
    localparam int SLOT_D = NODE_W + WT_W;
    localparam int NODE_D = 1 + DEPTH_W + CODE_W;
    localparam logic [8:0]         SYM_LIM = 9'(ALPHABET);
    localparam logic [CNT_W-1:0]   LAST_SYM = CNT_W'(ALPHABET - 1);
    localparam logic [DEPTH_W-1:0] MAX_LEN  = DEPTH_W'(MAX_CODE_LEN);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_s, n_s;
    logic [NODE_W-1:0] r_k, n_k;
    logic              r_h1, n_h1, r_h2, n_h2;
    logic [SLOT_W-1:0] r_b1, n_b1, r_b2, n_b2;
    logic [WT_W-1:0]   r_w1, n_w1, r_w2, n_w2;
    logic [NODE_W-1:0] r_n1, n_n1, r_n2, n_n2;
    logic [ALPHABET-1:0] r_freq_vld, n_freq_vld;
    logic [ALPHABET-1:0] r_slot_vld, n_slot_vld;
    logic [ALPHABET-1:0] r_coded, n_coded;
    logic              r_lk_ok, n_lk_ok;
    logic [SLOT_W-1:0] r_sym, n_sym;
    logic              r_out_vld, n_out_vld;
    t_out              r_out, n_out;

    // RAM ports
    logic                 freq_we, code_we, sym_we, slot_we, kids_we, node_we;
    logic [FREQ_BITS-1:0] freq_rd;
    logic [CODE_W-1:0]    code_rd;
    logic [LEN_W-1:0]     len_rd;
    logic [SLOT_W-1:0]    sym_rd;
    logic [SLOT_D-1:0]    slot_rd, slot_wd;
    logic [SLOT_W-1:0]    slot_wa, code_wa;
    logic [2*NODE_W-1:0]  kids_rd;
    logic [NODE_D-1:0]    node_rd, node_wd;
    logic [NODE_W-1:0]    node_wa;

    logic              w_acc, w_in_range, w_hit, w_last_scan, w_last_merge;
    logic [NODE_W-1:0] w_root, w_nn, w_s_node;
    logic [WT_W-1:0]   w_slot_w;
    logic [NODE_W-1:0] w_slot_n;
    logic              w_over_k, w_child_over;
    logic [DEPTH_W-1:0] w_len_k;
    logic [CODE_W-1:0]  w_code_k;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_vld && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_in_range = {1'b0, i_in_data.symbol} < SYM_LIM;

    assign w_hit        = r_freq_vld[r_cnt[SLOT_W-1:0]] && (freq_rd != '0);
    assign w_last_scan  = (r_cnt == CNT_W'(r_s - 1'b1));
    assign w_s_node     = NODE_W'(r_s);
    assign w_last_merge = (r_k == NODE_W'(w_s_node - NODE_W'(2)));
    assign w_root       = NODE_W'({r_s, 1'b0} - (CNT_W + 1)'(2));
    assign w_nn         = NODE_W'(w_s_node + r_k);
    assign w_slot_n     = slot_rd[SLOT_D-1:WT_W];
    assign w_slot_w     = slot_rd[WT_W-1:0];
    assign w_over_k     = node_rd[NODE_D-1];
    assign w_len_k      = node_rd[CODE_W +: DEPTH_W];
    assign w_code_k     = node_rd[CODE_W-1:0];
    assign w_child_over = w_over_k || (w_len_k >= MAX_LEN);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in_data.cmd)
                        CMD_BUILD:  n_state = S_COL_RD;
                        CMD_LOOKUP: n_state = S_LOOK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK:   n_state = S_IDLE;
            S_COL_RD: n_state = S_COL_EV;
            S_COL_EV: begin
                if (r_cnt == LAST_SYM) begin
                    if (r_s == '0 && !w_hit) begin
                        n_state = S_DONE;
                    end else if (r_s == CNT_W'(w_hit ? 0 : 1)) begin
                        n_state = S_T_ROOT;
                    end else begin
                        n_state = S_SC_RD;
                    end
                end else begin
                    n_state = S_COL_RD;
                end
            end
            S_SC_RD:  n_state = S_SC_EV;
            S_SC_EV:  n_state = w_last_scan ? S_MERGE : S_SC_RD;
            S_MERGE:  n_state = w_last_merge ? S_T_ROOT : S_SC_RD;
            S_T_ROOT: n_state = (r_s == CNT_W'(1)) ? S_L_RD : S_T_RD;
            S_T_RD:   n_state = S_T_W0;
            S_T_W0:   n_state = S_T_W1;
            S_T_W1:   n_state = (r_k == w_s_node) ? S_L_RD : S_T_RD;
            S_L_RD:   n_state = S_L_WR;
            S_L_WR:   n_state = (r_k == NODE_W'(w_s_node - 1'b1)) ? S_DONE : S_L_RD;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and result register
    always_comb begin
        n_cnt = r_cnt;  n_s = r_s;  n_k = r_k;
        n_h1 = r_h1;  n_h2 = r_h2;  n_b1 = r_b1;  n_b2 = r_b2;
        n_w1 = r_w1;  n_w2 = r_w2;  n_n1 = r_n1;  n_n2 = r_n2;
        n_freq_vld = r_freq_vld;  n_slot_vld = r_slot_vld;  n_coded = r_coded;
        n_lk_ok = r_lk_ok;  n_sym = r_sym;
        n_out_vld = r_out_vld && i_out_stall;
        n_out = r_out;
        freq_we = 1'b0;  code_we = 1'b0;  sym_we = 1'b0;
        slot_we = 1'b0;  kids_we = 1'b0;  node_we = 1'b0;
        slot_wa = r_s[SLOT_W-1:0];
        slot_wd = {w_s_node, WT_W'(freq_rd)};
        code_wa = sym_rd;
        node_wa = w_root;
        node_wd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in_data.cmd)
                        CMD_LOAD: begin
                            freq_we = w_in_range;
                            if (w_in_range) begin
                                n_freq_vld[i_in_data.symbol[SLOT_W-1:0]] = 1'b1;
                            end
                            n_out_vld = 1'b1;
                            n_out     = '0;
                        end
                        CMD_BUILD: begin
                            n_coded    = '0;
                            n_slot_vld = '0;
                            n_s        = '0;
                            n_cnt      = '0;
                        end
                        CMD_LOOKUP: begin
                            n_lk_ok = w_in_range;
                            n_sym   = i_in_data.symbol[SLOT_W-1:0];
                        end
                        default: begin
                            n_out_vld = 1'b1;
                            n_out     = '0;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_out_vld = 1'b1;
                n_out     = '0;
                if (r_lk_ok && r_coded[r_sym]) begin
                    n_out.code_bits = code_rd;
                    n_out.code_len  = len_rd;
                    n_out.has_code  = 1'b1;
                end
            end
            S_COL_EV: begin
                // append a nonzero symbol to the forest
                if (w_hit) begin
                    slot_we = 1'b1;
                    sym_we  = 1'b1;
                    n_slot_vld[r_s[SLOT_W-1:0]] = 1'b1;
                    n_s = r_s + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SYM) begin
                    n_cnt = '0;
                    n_k   = '0;
                    n_h1  = 1'b0;
                    n_h2  = 1'b0;
                end
            end
            S_SC_EV: begin
                // track first strict minimum and first minimum of the rest
                if (r_slot_vld[r_cnt[SLOT_W-1:0]]) begin
                    if (!r_h1 || w_slot_w < r_w1) begin
                        n_h2 = r_h1;  n_b2 = r_b1;  n_w2 = r_w1;  n_n2 = r_n1;
                        n_h1 = 1'b1;
                        n_b1 = r_cnt[SLOT_W-1:0];
                        n_w1 = w_slot_w;
                        n_n1 = w_slot_n;
                    end else if (!r_h2 || w_slot_w < r_w2) begin
                        n_h2 = 1'b1;
                        n_b2 = r_cnt[SLOT_W-1:0];
                        n_w2 = w_slot_w;
                        n_n2 = w_slot_n;
                    end
                end
                n_cnt = w_last_scan ? '0 : CNT_W'(r_cnt + 1'b1);
            end
            S_MERGE: begin
                // parent takes the right child's slot
                kids_we = 1'b1;
                slot_we = 1'b1;
                slot_wa = r_b2;
                slot_wd = {w_nn, WT_W'(r_w1 + r_w2)};
                n_slot_vld[r_b1] = 1'b0;
                n_k  = r_k + 1'b1;
                n_h1 = 1'b0;
                n_h2 = 1'b0;
            end
            S_T_ROOT: begin
                node_we = 1'b1;
                node_wa = w_root;
                node_wd = '0;
                n_k     = w_root;
            end
            S_T_W0: begin
                node_we = 1'b1;
                node_wa = kids_rd[2*NODE_W-1:NODE_W];
                node_wd = {w_child_over, DEPTH_W'(w_len_k + 1'b1),
                           w_code_k[CODE_W-2:0], 1'b0};
            end
            S_T_W1: begin
                node_we = 1'b1;
                node_wa = kids_rd[NODE_W-1:0];
                node_wd = {w_child_over, DEPTH_W'(w_len_k + 1'b1),
                           w_code_k[CODE_W-2:0], 1'b1};
                n_k = (r_k == w_s_node) ? '0 : NODE_W'(r_k - 1'b1);
            end
            S_L_WR: begin
                if (!w_over_k) begin
                    code_we = 1'b1;
                    n_coded[sym_rd] = 1'b1;
                end
                n_k = r_k + 1'b1;
            end
            S_DONE: begin
                n_out_vld  = 1'b1;
                n_out      = '0;
                n_out.status = (r_s == '0) ? ST_EMPTY : ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_freq_vld <= '0;
            r_coded    <= '0;
            r_slot_vld <= '0;
            r_out_vld  <= 1'b0;
            r_h1       <= 1'b0;
            r_h2       <= 1'b0;
            r_s        <= '0;
            r_cnt      <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_freq_vld <= n_freq_vld;
            r_coded    <= n_coded;
            r_slot_vld <= n_slot_vld;
            r_out_vld  <= n_out_vld;
            r_h1       <= n_h1;
            r_h2       <= n_h2;
            r_s        <= n_s;
            r_cnt      <= n_cnt;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_w1    <= n_w1;
        r_w2    <= n_w2;
        r_n1    <= n_n1;
        r_n2    <= n_n2;
        r_lk_ok <= n_lk_ok;
        r_sym   <= n_sym;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    hcb_ram #(.WIDTH(FREQ_BITS), .DEPTH(ALPHABET)) u_freq (
        .i_clk(i_clk), .i_we(freq_we),
        .i_waddr(i_in_data.symbol[SLOT_W-1:0]),
        .i_wdata(i_in_data.weight[FREQ_BITS-1:0]),
        .i_raddr(r_cnt[SLOT_W-1:0]), .o_rdata(freq_rd)
    );

    hcb_ram #(.WIDTH(CODE_W), .DEPTH(ALPHABET)) u_code (
        .i_clk(i_clk), .i_we(code_we), .i_waddr(code_wa),
        .i_wdata(w_code_k), .i_raddr(i_in_data.symbol[SLOT_W-1:0]),
        .o_rdata(code_rd)
    );

    hcb_ram #(.WIDTH(LEN_W), .DEPTH(ALPHABET)) u_len (
        .i_clk(i_clk), .i_we(code_we), .i_waddr(code_wa),
        .i_wdata(w_len_k[LEN_W-1:0]), .i_raddr(i_in_data.symbol[SLOT_W-1:0]),
        .o_rdata(len_rd)
    );

    hcb_ram #(.WIDTH(SLOT_W), .DEPTH(ALPHABET)) u_leaf_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(r_s[SLOT_W-1:0]),
        .i_wdata(r_cnt[SLOT_W-1:0]), .i_raddr(r_k[SLOT_W-1:0]),
        .o_rdata(sym_rd)
    );

    hcb_ram #(.WIDTH(SLOT_D), .DEPTH(ALPHABET)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_wa),
        .i_wdata(slot_wd), .i_raddr(r_cnt[SLOT_W-1:0]),
        .o_rdata(slot_rd)
    );

    hcb_ram #(.WIDTH(2 * NODE_W), .DEPTH(NODES)) u_kids (
        .i_clk(i_clk), .i_we(kids_we), .i_waddr(w_nn),
        .i_wdata({r_n1, r_n2}), .i_raddr(r_k), .o_rdata(kids_rd)
    );

    hcb_ram #(.WIDTH(NODE_D), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa),
        .i_wdata(node_wd), .i_raddr(r_k), .o_rdata(node_rd)
    );

    // A merge always has both children picked by the scan.
    a_merge_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MERGE |-> r_h1 && r_h2 && (r_b1 != r_b2))
        else $error("merge without two distinct roots");

    // The tree walk never descends into the leaf range.
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_T_RD |-> r_k >= w_s_node)
        else $error("tree walk index below leaf count");

    // The forest never holds more roots than symbols collected.
    a_forest_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SC_RD |-> $countones(r_slot_vld) <= int'(r_s))
        else $error("forest root count exceeds leaf count");

endmodule

// ===== hw/rtl/hcb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instanced for every store of the code builder.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
